// ===== hw/rtl/sha256_hash_engine_assert.svh =====
// Assertion macros used by the hash engine controller.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Clocked implication checked outside reset.
`define SHE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SHE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sha256_pkg.sv =====
// Types, constants and a rotate helper for the SHA-256 hash engine.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_byte;   // write byte at fill position, count length
    logic       start_block; // copy hash into working variables
    logic       do_round;    // one compression round
    logic       fold;        // add working variables into hash
    logic       pad_byte;    // write a padding byte at pad position
    logic       write_len;   // write the length into words 14 and 15
    logic       finish;      // reset hash and counters for the next message
    logic [7:0] pad_value;
    logic [5:0] pad_pos;
    logic [5:0] round;
    logic [2:0] emit_index;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [31:0] hash_word;
  } sha_stat_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RK_TAB [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hw/rtl/sha256_hash_engine.sv =====
// Top level of the SHA-256 streaming hash engine.
`timescale 1ns / 1ps
// Usage: one message byte per input request (in_valid/in_stall, in_item).
// A request with byte_present low and end_of_message low does nothing.
// end_of_message closes the message: padding and the length are appended,
// giving one or two final blocks, then eight digest words leave on the
// output channel (out_valid/out_stall, out_item), index 0 first.
// A byte that does not complete a block is taken while the engine stays idle. A byte
// that completes a 64-byte block starts the 64 rounds of the single round unit, then
// the fold, and no request is taken until they are done.
// The end of a message adds the padding bytes, the 64 rounds and the fold of each
// final block, and the eight digest words; one digest word leaves per cycle when
// not stalled.
// A stall on the output holds the current word; the engine waits.
// No input request is taken while a block or digest is in progress.
// Reset (rst, synchronous) loads the initial hash and clears the length,
// the fill count and all handshake state.
module sha256_hash_engine import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  sha_in_t  in_item,
  output logic     in_stall,
  output logic     out_valid,
  output sha_out_t out_item,
  input  logic     out_stall
);

  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  sha256_datapath u_dp (
    .clk(clk), .rst(rst),
    .msg_byte(in_item.msg_byte),
    .cmd(cmd), .stat(stat)
  );

endmodule

// ===== hw/rtl/sha256_datapath.sv =====
// SHA-256 datapath: message window, working variables, hash and length.
`timescale 1ns / 1ps
module sha256_datapath import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] msg_byte,
  input  sha_cmd_t   cmd,
  output sha_stat_t  stat
);

  logic [31:0] win [16];
  logic [31:0] wv [8];
  logic [31:0] hw [8];
  logic [63:0] bit_length;
  logic [5:0]  fill;

  logic [31:0] w_new, wt, s0w, s1w, t1, t2, big_s0, big_s1, ch, mj;
  logic [3:0]  r4;
  logic [5:0]  bpos;
  logic [7:0]  bval;
  logic        bwr;

  assign r4 = cmd.round[3:0];

  always_comb begin
    s0w = rotr(win[r4 + 4'd1], 7) ^ rotr(win[r4 + 4'd1], 18) ^ (win[r4 + 4'd1] >> 3);
    s1w = rotr(win[r4 + 4'd14], 17) ^ rotr(win[r4 + 4'd14], 19) ^ (win[r4 + 4'd14] >> 10);
    w_new = win[r4] + s0w + win[r4 + 4'd9] + s1w;
    wt = (cmd.round >= 6'd16) ? w_new : win[r4];
    big_s1 = rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25);
    ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1 = wv[7] + big_s1 + ch + RK_TAB[cmd.round] + wt;
    big_s0 = rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22);
    mj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t2 = big_s0 + mj;
    bwr = cmd.load_byte | cmd.pad_byte;
    bpos = cmd.load_byte ? fill : cmd.pad_pos;
    bval = cmd.load_byte ? msg_byte : cmd.pad_value;
  end

  always_ff @(posedge clk) begin
    if (bwr) begin
      case (bpos[1:0])
        2'd0: win[bpos[5:2]][31:24] <= bval;
        2'd1: win[bpos[5:2]][23:16] <= bval;
        2'd2: win[bpos[5:2]][15:8] <= bval;
        default: win[bpos[5:2]][7:0] <= bval;
      endcase
    end else if (cmd.write_len) begin
      win[14] <= bit_length[63:32];
      win[15] <= bit_length[31:0];
    end else if (cmd.do_round) begin
      win[r4] <= wt;
    end
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) wv[i] <= hw[i];
    end else if (cmd.do_round) begin
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < 8; i++) hw[i] <= IV_TAB[i];
      bit_length <= '0;
      fill <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hw[i] <= hw[i] + wv[i];
      end
      if (cmd.load_byte) begin
        bit_length <= bit_length + 64'd8;
        fill <= fill + 6'd1;
      end
    end
  end

  assign stat.fill = fill;
  assign stat.hash_word = hw[cmd.emit_index];

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
// SHA-256 controller: request handshake, padding sequence, rounds, output.
`timescale 1ns / 1ps
`include "sha256_hash_engine_assert.svh"
module sha256_ctrl import sha256_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  sha_in_t   in_item,
  output logic      in_stall,
  output logic      out_valid,
  output sha_out_t  out_item,
  input  logic      out_stall,
  input  sha_stat_t stat,
  output sha_cmd_t  cmd
);

  sha_state_t state, state_next;
  logic [5:0] cnt, cnt_next;        // round number, padding position
  logic [2:0] widx, widx_next;
  logic       pad_pend, pad_pend_next; // message end still needs padding
  logic       pad_more, pad_more_next; // another padding block follows this one
  logic       final_blk, final_blk_next; // current block is the last one
  logic       ovalid, ovalid_next;
  sha_out_t   oitem, oitem_next;
  logic       acc;

  assign in_stall = (state != ST_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_valid = ovalid;
  assign out_item = oitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
      cnt <= '0;
      widx <= '0;
      pad_pend <= 1'b0;
      pad_more <= 1'b0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
      cnt <= cnt_next;
      widx <= widx_next;
      pad_pend <= pad_pend_next;
      pad_more <= pad_more_next;
      final_blk <= final_blk_next;
    end
    oitem <= oitem_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    widx_next = widx;
    pad_pend_next = pad_pend;
    pad_more_next = pad_more;
    final_blk_next = final_blk;
    ovalid_next = ovalid && out_stall;
    oitem_next = oitem;
    cmd = '0;
    cmd.round = cnt;
    cmd.pad_pos = cnt;
    cmd.emit_index = widx;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd.load_byte = in_item.byte_present;
          pad_pend_next = in_item.end_of_message;
          final_blk_next = 1'b0;
          if (in_item.byte_present && stat.fill == 6'd63) begin
            cmd.start_block = 1'b1;
            cnt_next = '0;
            state_next = ST_ROUND;
          end else if (in_item.end_of_message) begin
            cnt_next = in_item.byte_present ? stat.fill + 6'd1 : stat.fill;
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // First pad byte is the marker, the rest are zero up to the block end
        // or up to the length field.
        cmd.pad_byte = 1'b1;
        cmd.pad_value = pad_pend ? PAD_MARK : 8'h00;
        pad_pend_next = 1'b0;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          // The marker landed at or past the start of the length field, so a second block follows.
          cmd.start_block = 1'b1;
          pad_more_next = 1'b1;
          cnt_next = '0;
          state_next = ST_ROUND;
        end else if (cnt == LEN_POS - 6'd1) begin
          // Last byte before the length field; the length goes in next cycle.
          final_blk_next = 1'b1;
        end else if (cnt == LEN_POS && final_blk) begin
          cmd.pad_byte = 1'b0;
          cmd.write_len = 1'b1;
          cmd.start_block = 1'b1;
          cnt_next = '0;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        cnt_next = '0;
        pad_more_next = 1'b0;
        if (final_blk) begin
          widx_next = '0;
          state_next = ST_EMIT;
        end else if (pad_pend || pad_more) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!ovalid || !out_stall) begin
          ovalid_next = 1'b1;
          oitem_next.digest_word = stat.hash_word;
          oitem_next.word_index = widx;
          oitem_next.last_word = (widx == 3'd7);
          widx_next = widx + 3'd1;
          if (widx == 3'd7) begin
            cmd.finish = 1'b1;
            final_blk_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SHE_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !acc, "accept while busy")
  `SHE_ASSERT_NEXT(a_round_wrap, clk, rst, state == ST_ROUND && cnt == 6'd63, state == ST_FOLD, "round count did not end in fold")
  `SHE_ASSERT_IMP(a_last_idx, clk, rst, out_valid && out_item.last_word, out_item.word_index == 3'd7, "last flag on wrong word")
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the SHA-256 streaming hash engine.
`timescale 1ns / 1ps
module tb_top;
  import sha256_pkg::*;

  logic     clk;
  logic     rst;
  logic     in_valid;
  sha_in_t  in_item;
  logic     in_stall;
  logic     out_valid;
  sha_out_t out_item;
  logic     out_stall;

  sha256_hash_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_item(in_item), .in_stall(in_stall),
    .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
  );

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };
  localparam int CYCLE_LIMIT = 400000;

  // Predictor state.
  logic [31:0] hash_acc [8];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_count;

  sha_in_t  pending_requests [$];
  sha_out_t expected_words [$];
  int       fail_count;
  int       cycle_count;
  int       burst_left;
  int       gap_left;
  int       hold_left;
  bit       stimulus_done;
  bit       hold_now;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic put_msg_byte(input logic [5:0] pos, input logic [7:0] b);
    logic [4:0] sh;
    sh = 5'(24 - 8 * pos[1:0]);
    msg_block[pos[5:2]] = (msg_block[pos[5:2]] & ~(32'hFF << sh)) | (32'(b) << sh);
  endtask

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] w, s0, s1, ch, mj, t1, t2, x, y;
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x = msg_block[(t - 15) & 15];
        y = msg_block[(t - 2) & 15];
        s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
        s1 = ror(y, 17) ^ ror(y, 19) ^ (y >> 10);
        msg_block[t & 15] = msg_block[t & 15] + s0 + msg_block[(t - 7) & 15] + s1;
      end
      w = msg_block[t & 15];
      s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + ROUND_K[t] + w;
      s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endtask

  task automatic predict_digest(input sha_in_t req);
    int p;
    sha_out_t o;
    if (req.byte_present) begin
      put_msg_byte(fill_count, req.msg_byte);
      msg_bits += 64'd8;
      fill_count += 6'd1;
      if (fill_count == 6'd0) compress_block();
    end
    if (req.end_of_message) begin
      p = fill_count;
      put_msg_byte(6'(p), 8'h80);
      p++;
      if (p > 56) begin
        for (; p < 64; p++) put_msg_byte(6'(p), 8'h00);
        compress_block();
        p = 0;
      end
      for (; p < 56; p++) put_msg_byte(6'(p), 8'h00);
      msg_block[14] = msg_bits[63:32];
      msg_block[15] = msg_bits[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_acc[i];
        o.word_index = 3'(i);
        o.last_word = (i == 7);
        expected_words = {expected_words, o};
      end
      for (int i = 0; i < 8; i++) hash_acc[i] = HASH_INIT[i];
      msg_bits = '0;
      fill_count = '0;
    end
  endtask

  task automatic queue_request(input logic [7:0] b, input logic present, input logic eom);
    sha_in_t r;
    r.msg_byte = b;
    r.byte_present = present;
    r.end_of_message = eom;
    pending_requests = {pending_requests, r};
  endtask

  // A message of random bytes, sometimes with ignored empty requests mixed in.
  task automatic queue_message(input int len, input bit close_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) queue_request(8'($urandom), 1'b0, 1'b0);
      queue_request(8'($urandom), 1'b1, close_with_byte && (i == len - 1));
    end
    if (!close_with_byte || len == 0) queue_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 8; i++) hash_acc[i] = HASH_INIT[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_bits = '0;
    fill_count = '0;
    fail_count = 0;
    stimulus_done = 1'b0;
    hold_now = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, byte extremes, ignored request, boundary lengths.
    queue_request(8'h00, 1'b0, 1'b1);
    queue_request(8'hFF, 1'b1, 1'b1);
    queue_request(8'h00, 1'b1, 1'b0);
    queue_request(8'h5A, 1'b0, 1'b0);
    queue_request(8'hA5, 1'b1, 1'b0);
    queue_request(8'h00, 1'b0, 1'b1);
    queue_message(55, 1'b1);
    queue_message(56, 1'b0);
    while (pending_requests.size() != 0 || expected_words.size() != 0) @(posedge clk);

    // The receiver is held off here long enough for the sender to back up.
    hold_now = 1'b1;
    queue_message(64, 1'b1);
    queue_message(3, 1'b1);
    while (pending_requests.size() != 0) @(posedge clk);
    hold_now = 1'b0;
    while (pending_requests.size() != 0 || expected_words.size() != 0) @(posedge clk);

    for (int m = 0; m < 6; m++) begin
      if ($urandom_range(0, 9) == 0) queue_message($urandom_range(60, 130), $urandom_range(0, 1));
      else queue_message($urandom_range(0, 12), $urandom_range(0, 1));
    end
    while (pending_requests.size() != 0) @(posedge clk);
    stimulus_done = 1'b1;
  end

  // Driver: bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      // After an accepted request is popped, the next one sits at the head.
      if (in_valid) void'(pending_requests.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0 && burst_left > 0) begin
        in_valid <= 1'b1;
        in_item <= pending_requests[0];
        burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  // Queue head is popped only when accepted; predictor runs on acceptance.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_digest(in_item);
  end

  // Receiver stall pattern, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_now && hold_left == 0) begin
      hold_left <= -600;
      out_stall <= 1'b1;
    end else if (hold_left < 0) begin
      hold_left <= (hold_left == -1) ? 1 : hold_left + 1;
      out_stall <= (hold_left != -1);
    end else begin
      if (hold_left == 1 && !hold_now) hold_left <= 0;
      out_stall <= ((cycle_count / 300) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    sha_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", out_item.digest_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_item.digest_word !== want.digest_word) begin
          $error("digest_word expected %h got %h", want.digest_word, out_item.digest_word);
          fail_count++;
        end
        if (out_item.word_index !== want.word_index) begin
          $error("word_index expected %0d got %0d", want.word_index, out_item.word_index);
          fail_count++;
        end
        if (out_item.last_word !== want.last_word) begin
          $error("last_word expected %0d got %0d", want.last_word, out_item.last_word);
          fail_count++;
        end
      end
    end
  end

  // End of run and cycle limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
      if (stimulus_done && !in_valid && expected_words.size() == 0) begin
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
      end
    end
  end

endmodule

// ===== sha256_hash_engine.f =====
+incdir+hw/rtl
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_datapath.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_hash_engine.sv
tb/tb_top.sv
